FILE: rtl/lcsr_pkg.sv
// Shared types, constants and helpers for the load-cell serial reader.
// No dependencies; every other file of the block imports this package.

package lcsr_pkg;

   // Default build parameters.
   localparam int DATA_BITS_DEF = 24;
   localparam int PULSES_DEF    = 25;

   // Fixed widths of the fixed-point reading and of the raw output port.
   localparam int Q_W       = 40;
   localparam int RAW_OUT_W = 24;

   // Register reset values.
   localparam logic [31:0] SCALE_A_RST = 32'd1523914;
   localparam logic [31:0] SCALE_B_RST = 32'd3023112;
   localparam logic [7:0]  PERIOD_RST  = 8'd21;
   localparam logic [7:0]  LOW_RST     = 8'd10;

   // Saturation limits of signed Q23.16.
   localparam logic signed [Q_W-1:0] Q40_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [Q_W-1:0] Q40_MIN = 40'sh80_0000_0000;

   // Command and channel codes carried by an input transfer.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_TARE = 1'b1;
   localparam logic CELL_A   = 1'b0;
   localparam logic CELL_B   = 1'b1;

   // Register map, one 32-bit word per register.
   typedef enum logic [1:0] {
      REG_SCALE_A,
      REG_SCALE_B,
      REG_PERIOD,
      REG_LOW
   } reg_idx_type;

   // Per-channel view of the pin side after one item.
   typedef struct packed {
      logic sck;
      logic done;
   } chan_status_type;

   // Saturate a 41-bit signed sum to the 40-bit Q23.16 range.
   function automatic logic signed [Q_W-1:0] sat41(input logic signed [Q_W:0] v);
      logic signed [Q_W-1:0] r;
      if (v > (Q_W+1)'(Q40_MAX)) begin
         r = Q40_MAX;
      end else if (v < (Q_W+1)'(Q40_MIN)) begin
         r = Q40_MIN;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/lcsr_channel.sv
// One converter channel: start detection, serial clock timing, bit capture
// and tare offset. Depends on lcsr_pkg.

module lcsr_channel #(
   parameter int DATA_BITS = lcsr_pkg::DATA_BITS_DEF,
   parameter int PULSES    = lcsr_pkg::PULSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            tick_en,
   input  logic                            tare_en,
   input  logic                            pin,
   input  logic signed [lcsr_pkg::Q_W-1:0] tare_value,
   input  logic [7:0]                      period_ticks,
   input  logic [7:0]                      low_ticks,
   output lcsr_pkg::chan_status_type       status,
   output logic signed [DATA_BITS-1:0]     raw_next,
   output logic signed [lcsr_pkg::Q_W-1:0] offset_next
);
   import lcsr_pkg::*;

   localparam int PC_W  = $clog2(PULSES + 1);
   localparam int BI_W  = $clog2(DATA_BITS);
   localparam int CNT_W = (PC_W > BI_W) ? PC_W : BI_W;

   logic                   busy_ff, busy_in;
   logic [7:0]             tick_ff, tick_in;
   logic [CNT_W-1:0]       pulse_ff, pulse_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;
   logic signed [DATA_BITS-1:0] raw_ff, raw_in;
   logic signed [Q_W-1:0]  offset_ff, offset_in;
   logic                   prev_ff, prev_in;
   logic                   done;
   logic [CNT_W-1:0]       pulse_inc;
   logic                   last_count;

   assign pulse_inc  = pulse_ff + CNT_W'(1);
   assign last_count = ({1'b0, tick_ff} + 9'd1) >= {1'b0, period_ticks};

   always_comb begin
      busy_in   = busy_ff;
      tick_in   = tick_ff;
      pulse_in  = pulse_ff;
      shift_in  = shift_ff;
      raw_in    = raw_ff;
      offset_in = offset_ff;
      prev_in   = prev_ff;
      done      = 1'b0;
      if (tick_en) begin
         if (busy_ff) begin
            if (last_count) begin
               // Sample MSB first while the pulse number still addresses a data bit.
               for (int i = 0; i < DATA_BITS; i++) begin
                  if (pin && (pulse_ff == CNT_W'(DATA_BITS - 1 - i))) begin
                     shift_in[i] = 1'b1;
                  end
               end
               tick_in  = 8'd0;
               pulse_in = pulse_inc;
               if (pulse_inc >= CNT_W'(PULSES)) begin
                  raw_in   = $signed(shift_in);
                  busy_in  = 1'b0;
                  pulse_in = '0;
                  done     = 1'b1;
               end
            end else begin
               tick_in = tick_ff + 8'd1;
            end
         end else if (prev_ff && !pin) begin
            busy_in  = 1'b1;
            tick_in  = 8'd0;
            pulse_in = '0;
            shift_in = '0;
         end
         prev_in = pin;
      end
      if (tare_en) begin
         offset_in = sat41((Q_W+1)'(offset_ff) - (Q_W+1)'(tare_value));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         tick_ff   <= 8'd0;
         pulse_ff  <= '0;
         shift_ff  <= '0;
         raw_ff    <= '0;
         offset_ff <= '0;
         prev_ff   <= 1'b1;
      end else begin
         busy_ff   <= busy_in;
         tick_ff   <= tick_in;
         pulse_ff  <= pulse_in;
         shift_ff  <= shift_in;
         raw_ff    <= raw_in;
         offset_ff <= offset_in;
         prev_ff   <= prev_in;
      end
   end

   assign status.sck  = busy_in && (tick_in >= low_ticks);
   assign status.done = done;
   assign raw_next    = raw_in;
   assign offset_next = offset_in;

endmodule

FILE: rtl/lcsr_calib.sv
// Calibration pipe for one channel: raw times scale, then offset and
// saturation into signed Q23.16. Depends on lcsr_pkg.

module lcsr_calib #(
   parameter int DATA_BITS = lcsr_pkg::DATA_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            load_prod,
   input  logic                            load_out,
   input  logic signed [DATA_BITS-1:0]     raw,
   input  logic signed [lcsr_pkg::Q_W-1:0] offset,
   input  logic [31:0]                     scale,
   output logic signed [lcsr_pkg::Q_W-1:0] reading
);
   import lcsr_pkg::*;

   localparam int PW = DATA_BITS + 33;
   localparam int QW = PW - 16;
   localparam int SW = ((QW > Q_W) ? QW : Q_W) + 1;

   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [Q_W-1:0] off_ff;
   logic signed [Q_W-1:0] reading_ff, reading_in;
   logic signed [QW-1:0]  quo;
   logic signed [SW-1:0]  sum;

   assign prod_in = PW'(raw) * PW'($signed({1'b0, scale}));

   // The arithmetic shift is a floor division by 2^16.
   assign quo = QW'(prod_ff >>> 16);
   assign sum = SW'(quo) + SW'(off_ff);

   always_comb begin
      if (sum > SW'(Q40_MAX)) begin
         reading_in = Q40_MAX;
      end else if (sum < SW'(Q40_MIN)) begin
         reading_in = Q40_MIN;
      end else begin
         reading_in = Q_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= prod_in;
         off_ff  <= offset;
      end
      if (load_out) begin
         reading_ff <= reading_in;
      end
   end

   assign reading = reading_ff;

endmodule

FILE: rtl/load_cell_serial_reader_unit.sv
// Two-channel load-cell serial reader, top level. Uses lcsr_pkg, lcsr_channel, lcsr_calib.
// A result is offered once its item has passed every register of the four-register pipe.
// Throughput: one item per cycle unless the result side stalls; the pipe (input, channel
// state, product, output) advances per stage, so it fills its bubbles under stall.
// Reset (synchronous, active high) idles both channels, clears offsets and raw words,
// restores register defaults and empties the pipe.

module load_cell_serial_reader_unit #(
   parameter int DATA_BITS = lcsr_pkg::DATA_BITS_DEF,
   parameter int PULSES    = lcsr_pkg::PULSES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_command,
   input  logic                                  req_din_a,
   input  logic                                  req_din_b,
   input  logic                                  req_cell_req,
   input  logic signed [lcsr_pkg::Q_W-1:0]       req_tare_value,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_sck_a,
   output logic                                  rsp_sck_b,
   output logic signed [lcsr_pkg::Q_W-1:0]       rsp_reading_a,
   output logic signed [lcsr_pkg::Q_W-1:0]       rsp_reading_b,
   output logic signed [lcsr_pkg::RAW_OUT_W-1:0] rsp_raw_a,
   output logic signed [lcsr_pkg::RAW_OUT_W-1:0] rsp_raw_b,
   output logic                                  rsp_done_a,
   output logic                                  rsp_done_b,
   // Configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [3:0]                            csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import lcsr_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers. Writes land at the access phase of a transfer;
   // the register index is the word address, so byte offsets are ignored.
   // ------------------------------------------------------------------
   logic [31:0] scale_a_ff, scale_b_ff;
   logic [7:0]  period_ff, low_ff;
   logic        csr_wr;
   reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_a_ff <= SCALE_A_RST;
         scale_b_ff <= SCALE_B_RST;
         period_ff  <= PERIOD_RST;
         low_ff     <= LOW_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SCALE_A: scale_a_ff <= csr_pwdata;
            REG_SCALE_B: scale_b_ff <= csr_pwdata;
            REG_PERIOD:  period_ff  <= csr_pwdata[7:0];
            REG_LOW:     low_ff     <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SCALE_A: csr_prdata = scale_a_ff;
         REG_SCALE_B: csr_prdata = scale_b_ff;
         REG_PERIOD:  csr_prdata = {24'd0, period_ff};
         REG_LOW:     csr_prdata = {24'd0, low_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipe control. Each stage may load when it is empty or when its
   // contents move on in the same cycle, so one stalled result does not
   // block the stages behind it while they still hold bubbles.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic rdy1, rdy2, rdy3, rdy_o;
   logic acc, adv1, adv2, adv3;

   assign rdy_o = !vo_ff || !rsp_stall;
   assign rdy3  = !v3_ff || rdy_o;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign adv3  = v3_ff && rdy_o;
   assign adv2  = v2_ff && rdy3;
   assign adv1  = v1_ff && rdy2;
   assign acc   = req_valid && rdy1;

   assign req_stall = !rdy1;
   assign rsp_valid = vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy_o) begin
            vo_ff <= v3_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: input register.
   // ------------------------------------------------------------------
   logic                  cmd1_ff, din_a1_ff, din_b1_ff, cell1_ff;
   logic signed [Q_W-1:0] tare1_ff;

   always_ff @(posedge clock) begin
      if (acc) begin
         cmd1_ff   <= req_command;
         din_a1_ff <= req_din_a;
         din_b1_ff <= req_din_b;
         cell1_ff  <= req_cell_req;
         tare1_ff  <= req_tare_value;
      end
   end

   // ------------------------------------------------------------------
   // Channel state moves exactly when the stage-1 item passes on. A tick
   // transfer clocks both channels; a tare transfer touches only the
   // offset of the chosen channel and leaves the pin history alone.
   // ------------------------------------------------------------------
   logic                        tick_en, tare_a_en, tare_b_en;
   chan_status_type             stat_a, stat_b;
   logic signed [DATA_BITS-1:0] raw_a_nx, raw_b_nx;
   logic signed [Q_W-1:0]       off_a_nx, off_b_nx;

   assign tick_en   = adv1 && (cmd1_ff == CMD_TICK);
   assign tare_a_en = adv1 && (cmd1_ff == CMD_TARE) && (cell1_ff == CELL_A);
   assign tare_b_en = adv1 && (cmd1_ff == CMD_TARE) && (cell1_ff == CELL_B);

   lcsr_channel #(
      .DATA_BITS (DATA_BITS),
      .PULSES    (PULSES)
   ) u_chan_a (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (tick_en),
      .tare_en      (tare_a_en),
      .pin          (din_a1_ff),
      .tare_value   (tare1_ff),
      .period_ticks (period_ff),
      .low_ticks    (low_ff),
      .status       (stat_a),
      .raw_next     (raw_a_nx),
      .offset_next  (off_a_nx)
   );

   lcsr_channel #(
      .DATA_BITS (DATA_BITS),
      .PULSES    (PULSES)
   ) u_chan_b (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (tick_en),
      .tare_en      (tare_b_en),
      .pin          (din_b1_ff),
      .tare_value   (tare1_ff),
      .period_ticks (period_ff),
      .low_ticks    (low_ff),
      .status       (stat_b),
      .raw_next     (raw_b_nx),
      .offset_next  (off_b_nx)
   );

   // ------------------------------------------------------------------
   // Stage 2: the channel view after the item (clock levels, completion
   // flags, raw word and offset), captured for the calibration pipe.
   // ------------------------------------------------------------------
   chan_status_type             stat2_a_ff, stat2_b_ff;
   logic signed [DATA_BITS-1:0] raw2_a_ff, raw2_b_ff;
   logic signed [Q_W-1:0]       off2_a_ff, off2_b_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         stat2_a_ff <= stat_a;
         stat2_b_ff <= stat_b;
         raw2_a_ff  <= raw_a_nx;
         raw2_b_ff  <= raw_b_nx;
         off2_a_ff  <= off_a_nx;
         off2_b_ff  <= off_b_nx;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: the product register lives in the calibration units; the
   // side-band fields travel alongside it here.
   // ------------------------------------------------------------------
   chan_status_type             stat3_a_ff, stat3_b_ff;
   logic signed [DATA_BITS-1:0] raw3_a_ff, raw3_b_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         stat3_a_ff <= stat2_a_ff;
         stat3_b_ff <= stat2_b_ff;
         raw3_a_ff  <= raw2_a_ff;
         raw3_b_ff  <= raw2_b_ff;
      end
   end

   lcsr_calib #(
      .DATA_BITS (DATA_BITS)
   ) u_calib_a (
      .clock     (clock),
      .load_prod (adv2),
      .load_out  (adv3),
      .raw       (raw2_a_ff),
      .offset    (off2_a_ff),
      .scale     (scale_a_ff),
      .reading   (rsp_reading_a)
   );

   lcsr_calib #(
      .DATA_BITS (DATA_BITS)
   ) u_calib_b (
      .clock     (clock),
      .load_prod (adv2),
      .load_out  (adv3),
      .raw       (raw2_b_ff),
      .offset    (off2_b_ff),
      .scale     (scale_b_ff),
      .reading   (rsp_reading_b)
   );

   // ------------------------------------------------------------------
   // Output register. The raw word is shown in 24 bits, sign-extended or
   // cut down to its low bits as the word width demands.
   // ------------------------------------------------------------------
   chan_status_type               stat_o_a_ff, stat_o_b_ff;
   logic signed [RAW_OUT_W-1:0]   raw_o_a_ff, raw_o_b_ff;

   always_ff @(posedge clock) begin
      if (adv3) begin
         stat_o_a_ff <= stat3_a_ff;
         stat_o_b_ff <= stat3_b_ff;
         raw_o_a_ff  <= RAW_OUT_W'(raw3_a_ff);
         raw_o_b_ff  <= RAW_OUT_W'(raw3_b_ff);
      end
   end

   assign rsp_sck_a  = stat_o_a_ff.sck;
   assign rsp_sck_b  = stat_o_b_ff.sck;
   assign rsp_done_a = stat_o_a_ff.done;
   assign rsp_done_b = stat_o_b_ff.done;
   assign rsp_raw_a  = raw_o_a_ff;
   assign rsp_raw_b  = raw_o_b_ff;

`ifndef SYNTHESIS
   // A channel that has just finished is idle, so its clock line is low.
   a_done_clock_low : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_done_a || rsp_done_b)) |->
         !((rsp_done_a && rsp_sck_a) || (rsp_done_b && rsp_sck_b)))
      else $error("serial clock high on a completing channel");

   // A tare transfer never completes a conversion.
   a_tare_no_done : assert property (@(posedge clock) disable iff (reset)
      (adv1 && (cmd1_ff == CMD_TARE)) |=> (!stat2_a_ff.done && !stat2_b_ff.done))
      else $error("completion flagged on a tare transfer");

   // Back-pressure at the input only arises when the input stage is occupied.
   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("input stalled with an empty input stage");
`endif

endmodule
